// File: hdl/bemf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bemf_pkg
// shared types, constants and tables for the back-emf observer with pll
// ----------------------------------------------------------------------------
package bemf_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int ANGLE_BITS_DEF  = 16;

  // shared multiplier and accumulator widths
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = PROD_W + 2;

  // cordic
  localparam int CORDIC_STAGES = 14;
  localparam int CORDIC_W      = 20;
  localparam int Z_W           = 17;
  localparam int CORDIC_X0     = 39797;

  // register reset values
  localparam logic        MODE_RST       = 1'b0;
  localparam logic [19:0] RESISTANCE_RST = 20'd13107;
  localparam logic [23:0] L_OVER_T_RST   = 24'd1449984;
  localparam logic [15:0] R_T_OVER_L_RST = 16'd590;
  localparam logic [15:0] T_OVER_L_RST   = 16'd2962;
  localparam logic [31:0] ANGLE_GAIN_RST = 32'd22557;

  typedef enum logic [2:0] {
    REG_MODE,
    REG_RESISTANCE,
    REG_L_OVER_T,
    REG_R_T_OVER_L,
    REG_T_OVER_L,
    REG_PLL_KP,
    REG_PLL_KI,
    REG_ANGLE_GAIN
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_P_LOAD,
    S_P_SUB,
    S_P_ADD,
    S_P_END,
    S_E_LOAD,
    S_E_SUB,
    S_E_ACC,
    S_E_END,
    S_C_WAIT,
    S_ER_LOAD,
    S_ER_SUB1,
    S_ER_SUB2,
    S_ER_END,
    S_I_LOAD,
    S_I_ACC,
    S_I_END,
    S_S_LOAD,
    S_S_END,
    S_A_LOAD,
    S_A_ACC,
    S_A_END,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                       done;
    logic signed [CORDIC_W-1:0] cos_val;
    logic signed [CORDIC_W-1:0] sin_val;
  } cordic_out_t;

  // arctangent table in 1/65536 turn
  function automatic logic [13:0] cordic_atan(input logic [3:0] k);
    logic [13:0] r;
    case (k)
      4'd0:    r = 14'd8192;
      4'd1:    r = 14'd4836;
      4'd2:    r = 14'd2555;
      4'd3:    r = 14'd1297;
      4'd4:    r = 14'd651;
      4'd5:    r = 14'd326;
      4'd6:    r = 14'd163;
      4'd7:    r = 14'd81;
      4'd8:    r = 14'd41;
      4'd9:    r = 14'd20;
      4'd10:   r = 14'd10;
      4'd11:   r = 14'd5;
      4'd12:   r = 14'd3;
      4'd13:   r = 14'd1;
      default: r = 14'd0;
    endcase
    return r;
  endfunction

  // saturate an accumulator value to 32 bits signed
  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    logic signed [31:0]      r;
    hi = ACC_W'(64'sh7FFF_FFFF);
    lo = -hi - ACC_W'(1);
    if (x > hi) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < lo) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/bemf_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bemf_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module bemf_mul (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic signed [bemf_pkg::MUL_W-1:0]  a,
  input  wire logic signed [bemf_pkg::MUL_W-1:0]  b,
  output logic signed      [bemf_pkg::PROD_W-1:0] prod
);
  import bemf_pkg::*;

  // product holds while not issued
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule
`default_nettype wire

// File: hdl/bemf_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bemf_cordic
// iterative cordic, one rotation per cycle, gives cos and sin in q16
// ----------------------------------------------------------------------------
module bemf_cordic (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] angle,
  output bemf_pkg::cordic_out_t res
);
  import bemf_pkg::*;

  logic signed [CORDIC_W-1:0] x;
  logic signed [CORDIC_W-1:0] y;
  logic signed [Z_W-1:0]      z;
  logic [3:0]                 k;
  logic [1:0]                 quad;
  logic                       busy;
  logic                       done;
  logic signed [CORDIC_W-1:0] dx;
  logic signed [CORDIC_W-1:0] dy;
  logic signed [Z_W-1:0]      at;

  assign dx = y >>> k;
  assign dy = x >>> k;
  assign at = $signed(Z_W'(cordic_atan(k)));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      k    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= CORDIC_W'(CORDIC_X0);
        y    <= '0;
        z    <= $signed(Z_W'(angle[13:0]));
        quad <= angle[15:14];
        k    <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (!z[Z_W-1]) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - at;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + at;
        end
        k <= k + 4'd1;
        if (k == 4'(CORDIC_STAGES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quadrant fold
  always_comb begin
    res.done = done;
    case (quad)
      2'd0: begin
        res.cos_val = x;
        res.sin_val = y;
      end
      2'd1: begin
        res.cos_val = -y;
        res.sin_val = x;
      end
      2'd2: begin
        res.cos_val = -x;
        res.sin_val = -y;
      end
      default: begin
        res.cos_val = y;
        res.sin_val = -x;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/back_emf_observer_pll_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// back_emf_observer_pll_unit
// sensorless back-emf observer with pi pll speed and angle tracker
// ----------------------------------------------------------------------------
//  channel   | direction | handshake        | contents
//  ----------+-----------+------------------+-------------------------------
//  s_*       | in        | tvalid / tready  | v_alpha, v_beta, i_alpha, i_beta
//  m_*       | out       | tvalid / tready  | emf_a/b, angle, speed, error
//  cfg_*     | in        | cfg_we only      | register index and write data
//
//  a sample is worked in sequenced steps, more in predictor-corrector mode:
//  every product goes through one shared registered multiplier under the
//  sequencer, and sine/cosine come from an iterative cordic.
//  s_tready is high only while the sequencer is idle; a finished result waits
//  in the output register, and a new transfer can be taken meanwhile.
//  the last step stalls only when the previous result is still not taken.
//  rst is synchronous: it restores register defaults and the observer/pll state.
// ----------------------------------------------------------------------------
module back_emf_observer_pll_unit #(
  parameter int SAMPLE_BITS = bemf_pkg::SAMPLE_BITS_DEF,
  parameter int ANGLE_BITS  = bemf_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // v_alpha, v_beta, i_alpha, i_beta from lowest bit up
  input  wire logic [((4*SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  // emf_alpha, emf_beta, rotor_angle, rotor_speed, phase_error from lowest bit up
  output logic [((2*SAMPLE_BITS+80+7)/8)*8-1:0]       m_tdata,
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  input  wire logic                                   cfg_we,
  input  wire logic [2:0]                             cfg_addr,
  input  wire logic [31:0]                            cfg_wdata
);
  import bemf_pkg::*;

  localparam int OUT_W = ((2*SAMPLE_BITS+80+7)/8)*8;
  localparam int PW    = SAMPLE_BITS + 2;
  localparam int ASH   = 48 - ANGLE_BITS;
  localparam logic signed [ACC_W-1:0] HALF16  = ACC_W'(64'd32768);
  localparam logic signed [ACC_W-1:0] HALF17  = ACC_W'(64'd65536);
  localparam logic signed [ACC_W-1:0] HALF_A  = ACC_W'(64'd1 << (ASH - 1));
  localparam logic signed [ACC_W-1:0] EMF_MAX = ACC_W'((64'd1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] EMF_MIN = -EMF_MAX - ACC_W'(1);

  // configuration registers
  logic        mode;
  logic [19:0] resistance;
  logic [23:0] l_over_t;
  logic [15:0] r_t_over_l;
  logic [15:0] t_over_l;
  logic signed [31:0] pll_kp;
  logic signed [31:0] pll_ki;
  logic [31:0] angle_gain;

  // observer and pll state
  logic signed [SAMPLE_BITS-1:0] last_i_alpha;
  logic signed [SAMPLE_BITS-1:0] last_i_beta;
  logic signed [SAMPLE_BITS-1:0] est_emf_alpha;
  logic signed [SAMPLE_BITS-1:0] est_emf_beta;
  logic signed [31:0]            speed_integral;
  logic [ANGLE_BITS-1:0]         track_angle;

  // working registers
  state_t state;
  state_t state_next;
  logic   axis;
  logic signed [SAMPLE_BITS-1:0] v_alpha;
  logic signed [SAMPLE_BITS-1:0] v_beta;
  logic signed [SAMPLE_BITS-1:0] i_alpha;
  logic signed [SAMPLE_BITS-1:0] i_beta;
  logic signed [PW-1:0]          pred;
  logic signed [ACC_W-1:0]       acc;
  logic signed [31:0]            phase_error;
  logic signed [31:0]            rotor_speed;

  // shared multiplier issue
  logic                     mul_en;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic                     cordic_start;
  cordic_out_t              cordic_res;

  // current axis operands
  logic signed [SAMPLE_BITS-1:0] cur_v;
  logic signed [SAMPLE_BITS-1:0] cur_i;
  logic signed [SAMPLE_BITS-1:0] cur_last_i;
  logic signed [SAMPLE_BITS-1:0] cur_e;
  logic signed [ACC_W-1:0]       emf_shifted;
  logic signed [SAMPLE_BITS-1:0] emf_sat;
  logic [15:0]                   angle16;
  logic                          out_free;

  assign cur_v      = axis ? v_beta : v_alpha;
  assign cur_i      = axis ? i_beta : i_alpha;
  assign cur_last_i = axis ? last_i_beta : last_i_alpha;
  assign cur_e      = axis ? est_emf_beta : est_emf_alpha;
  assign out_free   = !m_tvalid || m_tready;

  // tracked angle scaled to a 16-bit turn
  assign angle16 = 16'({track_angle, 8'd0} >> (ANGLE_BITS - 8));

  // rounding offset already sits in acc; mode 1 carries one extra bit
  assign emf_shifted = mode ? (acc >>> 17) : (acc >>> 16);
  always_comb begin
    if (emf_shifted > EMF_MAX) begin
      emf_sat = EMF_MAX[SAMPLE_BITS-1:0];
    end else if (emf_shifted < EMF_MIN) begin
      emf_sat = EMF_MIN[SAMPLE_BITS-1:0];
    end else begin
      emf_sat = emf_shifted[SAMPLE_BITS-1:0];
    end
  end

  bemf_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  bemf_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .angle (angle16),
    .res   (cordic_res)
  );

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (s_tvalid) state_next = mode ? S_P_LOAD : S_E_LOAD;
      S_P_LOAD:  state_next = S_P_SUB;
      S_P_SUB:   state_next = S_P_ADD;
      S_P_ADD:   state_next = S_P_END;
      S_P_END:   state_next = S_E_LOAD;
      S_E_LOAD:  state_next = S_E_SUB;
      S_E_SUB:   state_next = S_E_ACC;
      S_E_ACC:   state_next = S_E_END;
      S_E_END: begin
        if (axis) begin
          state_next = S_C_WAIT;
        end else begin
          state_next = mode ? S_P_LOAD : S_E_LOAD;
        end
      end
      S_C_WAIT:  if (cordic_res.done) state_next = S_ER_LOAD;
      S_ER_LOAD: state_next = S_ER_SUB1;
      S_ER_SUB1: state_next = S_ER_SUB2;
      S_ER_SUB2: state_next = S_ER_END;
      S_ER_END:  state_next = S_I_LOAD;
      S_I_LOAD:  state_next = S_I_ACC;
      S_I_ACC:   state_next = S_I_END;
      S_I_END:   state_next = S_S_LOAD;
      S_S_LOAD:  state_next = S_S_END;
      S_S_END:   state_next = S_A_LOAD;
      S_A_LOAD:  state_next = S_A_ACC;
      S_A_ACC:   state_next = S_A_END;
      S_A_END:   state_next = S_DONE;
      S_DONE:    if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // sequencer outputs: multiplier operands, cordic kick, input ready
  always_comb begin
    mul_en       = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    cordic_start = 1'b0;
    s_tready     = 1'b0;
    case (state)
      S_IDLE: s_tready = 1'b1;
      S_P_LOAD: begin
        // rt/l times current
        mul_en = 1'b1;
        mul_a  = $signed(MUL_W'(r_t_over_l));
        mul_b  = MUL_W'(cur_i);
      end
      S_P_SUB: begin
        // t/l times (v - last emf)
        mul_en = 1'b1;
        mul_a  = $signed(MUL_W'(t_over_l));
        mul_b  = MUL_W'(cur_v) - MUL_W'(cur_e);
      end
      S_E_LOAD: begin
        mul_en = 1'b1;
        mul_a  = $signed(MUL_W'(resistance));
        mul_b  = MUL_W'(cur_i);
      end
      S_E_SUB: begin
        // l/t times current change, predicted current in mode 1
        mul_en = 1'b1;
        mul_a  = $signed(MUL_W'(l_over_t));
        mul_b  = mode ? (MUL_W'(pred) - MUL_W'(cur_last_i))
                      : (MUL_W'(cur_i) - MUL_W'(cur_last_i));
      end
      S_E_END: cordic_start = axis;
      S_ER_LOAD: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(est_emf_alpha);
        mul_b  = MUL_W'(cordic_res.cos_val);
      end
      S_ER_SUB1: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(est_emf_beta);
        mul_b  = MUL_W'(cordic_res.sin_val);
      end
      S_I_LOAD: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(pll_ki);
        mul_b  = MUL_W'(phase_error);
      end
      S_I_ACC: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(pll_kp);
        mul_b  = MUL_W'(phase_error);
      end
      S_A_LOAD: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(rotor_speed);
        mul_b  = $signed(MUL_W'(angle_gain));
      end
      default: ;
    endcase
  end

  // datapath, configuration and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      axis           <= 1'b0;
      m_tvalid       <= 1'b0;
      mode           <= MODE_RST;
      resistance     <= RESISTANCE_RST;
      l_over_t       <= L_OVER_T_RST;
      r_t_over_l     <= R_T_OVER_L_RST;
      t_over_l       <= T_OVER_L_RST;
      pll_kp         <= '0;
      pll_ki         <= '0;
      angle_gain     <= ANGLE_GAIN_RST;
      last_i_alpha   <= '0;
      last_i_beta    <= '0;
      est_emf_alpha  <= '0;
      est_emf_beta   <= '0;
      speed_integral <= '0;
      track_angle    <= '0;
    end else begin
      state <= state_next;
      // a new result replaces one taken in the same cycle
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          REG_MODE:       mode       <= cfg_wdata[0];
          REG_RESISTANCE: resistance <= cfg_wdata[19:0];
          REG_L_OVER_T:   l_over_t   <= cfg_wdata[23:0];
          REG_R_T_OVER_L: r_t_over_l <= cfg_wdata[15:0];
          REG_T_OVER_L:   t_over_l   <= cfg_wdata[15:0];
          REG_PLL_KP:     pll_kp     <= $signed(cfg_wdata);
          REG_PLL_KI:     pll_ki     <= $signed(cfg_wdata);
          REG_ANGLE_GAIN: angle_gain <= cfg_wdata;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            v_alpha <= $signed(s_tdata[0 +: SAMPLE_BITS]);
            v_beta  <= $signed(s_tdata[SAMPLE_BITS +: SAMPLE_BITS]);
            i_alpha <= $signed(s_tdata[2*SAMPLE_BITS +: SAMPLE_BITS]);
            i_beta  <= $signed(s_tdata[3*SAMPLE_BITS +: SAMPLE_BITS]);
            axis    <= 1'b0;
          end
        end
        // current prediction
        S_P_LOAD: acc  <= (ACC_W'(cur_i) <<< 16) + HALF16;
        S_P_SUB:  acc  <= acc - ACC_W'(prod);
        S_P_ADD:  acc  <= acc + ACC_W'(prod);
        S_P_END:  pred <= acc[16 +: PW];
        // emf estimate
        S_E_LOAD: acc <= mode ? ((ACC_W'(cur_v) <<< 17) + HALF17)
                              : ((ACC_W'(cur_v) <<< 16) + HALF16);
        S_E_SUB:  acc <= mode ? (acc - (ACC_W'(prod) <<< 1)) : (acc - ACC_W'(prod));
        S_E_ACC:  acc <= acc - ACC_W'(prod);
        S_E_END: begin
          if (axis) begin
            est_emf_beta <= emf_sat;
            last_i_beta  <= cur_i;
          end else begin
            est_emf_alpha <= emf_sat;
            last_i_alpha  <= cur_i;
          end
          axis <= 1'b1;
        end
        // phase detector
        S_ER_LOAD: acc <= '0;
        S_ER_SUB1: acc <= acc - ACC_W'(prod);
        S_ER_SUB2: acc <= acc - ACC_W'(prod);
        S_ER_END:  phase_error <= sat32(acc);
        // integrator
        S_I_LOAD: acc <= (ACC_W'(speed_integral) <<< 16) + HALF16;
        S_I_ACC:  acc <= acc + ACC_W'(prod);
        S_I_END:  speed_integral <= sat32(acc >>> 16);
        // speed, proportional product still held in the multiplier
        S_S_LOAD: acc <= (ACC_W'(speed_integral) <<< 16) + HALF16 + ACC_W'(prod);
        S_S_END:  rotor_speed <= sat32(acc >>> 16);
        // angle advance, wraps modulo one turn
        S_A_LOAD: acc <= HALF_A;
        S_A_ACC:  acc <= acc + ACC_W'(prod);
        S_A_END:  track_angle <= track_angle + acc[ASH +: ANGLE_BITS];
        S_DONE: begin
          if (out_free) begin
            m_tdata <= OUT_W'({phase_error, rotor_speed, angle16,
                               est_emf_beta, est_emf_alpha});
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sim/bemf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bemf_checker
// watches the sample and result channels, predicts the observer and pll
// outputs and compares every result transfer with the oldest prediction
// ----------------------------------------------------------------------------
module bemf_checker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [63:0]  s_tdata,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [111:0] m_tdata,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [31:0]  cfg_wdata,
  output int                fails,
  output int                pending
);
  import bemf_pkg::*;

  typedef struct {
    logic signed [15:0] emf_a;
    logic signed [15:0] emf_b;
    logic [15:0]        angle;
    logic signed [31:0] speed;
    logic signed [31:0] err;
  } bemf_result_t;

  bemf_result_t estimates[$];

  // register copy
  logic        obs_mode;
  longint      res_q16, lt_q16, rtl_q16, tl_q16, kp_q16, ki_q16, gain;
  // observer and pll state
  longint      prev_ia, prev_ib, prev_ea, prev_eb, integ;
  logic [15:0] angle_acc;

  longint atan_tab[14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};

  function automatic longint round_shift(input longint x, input int n);
    return (x + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp(input longint x, input int n);
    longint hi;
    hi = (longint'(1) <<< (n - 1)) - 1;
    if (x > hi) return hi;
    if (x < -hi - 1) return -hi - 1;
    return x;
  endfunction

  function automatic longint emf_estimate(input longint v, input longint i,
                                          input longint li, input longint le);
    longint p, acc;
    if (obs_mode) begin
      p = round_shift(i * 65536 - rtl_q16 * i + tl_q16 * (v - le), 16);
      acc = round_shift(v * 131072 - 2 * res_q16 * i - lt_q16 * (p - li), 17);
    end else begin
      acc = round_shift(v * 65536 - res_q16 * i - lt_q16 * (i - li), 16);
    end
    return clamp(acc, 16);
  endfunction

  // iterative rotation on the first quadrant, then quadrant fold
  task automatic rotate(input logic [15:0] a, output longint c, output longint s);
    longint x, y, z, dx, dy;
    x = CORDIC_X0;
    y = 0;
    z = a[13:0];
    for (int k = 0; k < 14; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[k];
      end else begin
        x += dx; y -= dy; z += atan_tab[k];
      end
    end
    case (a[15:14])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  task automatic predict(input logic [63:0] d);
    bemf_result_t r;
    longint ea, eb, c, s, e, spd, stp;
    ea = emf_estimate(longint'($signed(d[15:0])), longint'($signed(d[47:32])), prev_ia, prev_ea);
    eb = emf_estimate(longint'($signed(d[31:16])), longint'($signed(d[63:48])), prev_ib, prev_eb);
    prev_ea = ea;
    prev_eb = eb;
    prev_ia = $signed(d[47:32]);
    prev_ib = $signed(d[63:48]);
    rotate(angle_acc, c, s);
    e = clamp(-(ea * c + eb * s), 32);
    integ = clamp(integ + round_shift(ki_q16 * e, 16), 32);
    spd = clamp(integ + round_shift(kp_q16 * e, 16), 32);
    stp = round_shift(spd * gain, 32);
    angle_acc = angle_acc + stp[15:0];
    r.emf_a = ea[15:0];
    r.emf_b = eb[15:0];
    r.angle = angle_acc;
    r.speed = spd[31:0];
    r.err = e[31:0];
    estimates.push_back(r);
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fails++;
  endtask

  always @(posedge clk) begin
    bemf_result_t w;
    if (rst) begin
      obs_mode = MODE_RST;
      res_q16 = RESISTANCE_RST;
      lt_q16 = L_OVER_T_RST;
      rtl_q16 = R_T_OVER_L_RST;
      tl_q16 = T_OVER_L_RST;
      kp_q16 = 0;
      ki_q16 = 0;
      gain = ANGLE_GAIN_RST;
      prev_ia = 0; prev_ib = 0; prev_ea = 0; prev_eb = 0; integ = 0;
      angle_acc = '0;
      estimates.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          REG_MODE:       obs_mode = cfg_wdata[0];
          REG_RESISTANCE: res_q16 = cfg_wdata[19:0];
          REG_L_OVER_T:   lt_q16 = cfg_wdata[23:0];
          REG_R_T_OVER_L: rtl_q16 = cfg_wdata[15:0];
          REG_T_OVER_L:   tl_q16 = cfg_wdata[15:0];
          REG_PLL_KP:     kp_q16 = $signed(cfg_wdata);
          REG_PLL_KI:     ki_q16 = $signed(cfg_wdata);
          REG_ANGLE_GAIN: gain = cfg_wdata;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict(s_tdata);
      if (m_tvalid && m_tready) begin
        if (estimates.size() == 0) begin
          report("unexpected result transfer", 1, 0);
        end else begin
          w = estimates.pop_front();
          if ($signed(m_tdata[15:0]) != w.emf_a)
            report("emf_alpha", $signed(m_tdata[15:0]), w.emf_a);
          if ($signed(m_tdata[31:16]) != w.emf_b)
            report("emf_beta", $signed(m_tdata[31:16]), w.emf_b);
          if (m_tdata[47:32] != w.angle)
            report("rotor_angle", m_tdata[47:32], w.angle);
          if ($signed(m_tdata[79:48]) != w.speed)
            report("rotor_speed", $signed(m_tdata[79:48]), w.speed);
          if ($signed(m_tdata[111:80]) != w.err)
            report("phase_error", $signed(m_tdata[111:80]), w.err);
        end
      end
    end
    pending = estimates.size();
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// back-emf observer with pll: directed extremes, then random samples under
// several register settings, with bursty input and a stalling receiver
// ----------------------------------------------------------------------------
module testbench;
  import bemf_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 60;   // margin beyond the sample latency

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic [63:0]  s_tdata = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [111:0] m_tdata;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_addr = '0;
  logic [31:0]  cfg_wdata = '0;
  int           fails;
  int           pending;
  int           cycles = 0;
  int           burst_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  back_emf_observer_pll_unit i_dut (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  bemf_checker i_checker (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .fails(fails), .pending(pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver stall pattern: the style changes with bits 9:8 of the cycle count
  always @(posedge clk) begin
    case (cycles[9:8])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= 1'($urandom_range(0, 1));
      2'd2: m_tready <= (cycles[5:0] < 6'd40);
      default: m_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // one register write per cycle; caller lowers cfg_we after a batch
  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // one sample transfer, with the burst and gap pattern of the sender
  task automatic send_sample(input logic [15:0] va, input logic [15:0] vb,
                             input logic [15:0] ia, input logic [15:0] ib);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tdata <= {ib, ia, vb, va};
    s_tvalid <= 1'b1;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
  endtask

  // sender pause until the result queue is empty, then the latency margin
  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value(input logic [31:0] top, input logic [31:0] typ);
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return top;
      2: return $urandom();            // upper bits exercise the register width
      default: return $urandom_range(0, typ);
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom();
      3: return 32'd0;
      default: return $signed($urandom_range(0, 400000)) - 200000;
    endcase
  endfunction

  function automatic logic [15:0] pick_field();
    case ($urandom_range(0, 4))
      0: return 16'($urandom());
      1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return 16'($signed($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // predictor-corrector before any sample: previous current and emf are zero
    write_reg(REG_MODE, 32'hFFFF_FFFF);
    write_reg(REG_PLL_KP, 32'd300000);
    write_reg(REG_PLL_KI, 32'd20000);
    cfg_we <= 1'b0;
    @(posedge clk);
    send_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_sample(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA);
    send_sample(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
    drain();

    // plain voltage model, large positive gains: fast upward angle wrap
    write_reg(REG_MODE, 32'hFFFF_FFFE);
    write_reg(REG_PLL_KP, 32'h7FFF_FFFF);
    write_reg(REG_PLL_KI, 32'h7FFF_FFFF);
    write_reg(REG_ANGLE_GAIN, 32'hFFFF_FFFF);
    cfg_we <= 1'b0;
    @(posedge clk);
    for (int k = 0; k < 6; k++)
      send_sample(k[0] ? 16'h7FFF : 16'h8000, 16'h1234, 16'h8000, k[1] ? 16'h7FFF : 16'h0);
    drain();

    // negative gains turn the speed negative: angle wraps downward
    write_reg(REG_PLL_KP, 32'h8000_0000);
    write_reg(REG_PLL_KI, 32'hFFFF_0000);
    write_reg(REG_RESISTANCE, 32'hFFFF_FFFF);
    write_reg(REG_L_OVER_T, 32'hFFFF_FFFF);
    write_reg(REG_R_T_OVER_L, 32'hFFFF_FFFF);
    write_reg(REG_T_OVER_L, 32'hFFFF_FFFF);
    cfg_we <= 1'b0;
    @(posedge clk);
    for (int k = 0; k < 8; k++)
      send_sample(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()));
    drain();

    // random phases, each with its own register setting
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_MODE, $urandom());
      write_reg(REG_RESISTANCE, pick_value(32'hF_FFFF, 40000));
      write_reg(REG_L_OVER_T, pick_value(32'hFF_FFFF, 3000000));
      write_reg(REG_R_T_OVER_L, pick_value(32'hFFFF, 2000));
      write_reg(REG_T_OVER_L, pick_value(32'hFFFF, 8000));
      write_reg(REG_PLL_KP, pick_gain());
      write_reg(REG_PLL_KI, pick_gain());
      write_reg(REG_ANGLE_GAIN, pick_value(32'hFFFF_FFFF, 200000));
      cfg_we <= 1'b0;
      @(posedge clk);
      for (int n = 0; n < 125; n++)
        send_sample(pick_field(), pick_field(), pick_field(), pick_field());
      drain();
    end

    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: back_emf_observer_pll_unit.f
hdl/bemf_pkg.sv
hdl/bemf_mul.sv
hdl/bemf_cordic.sv
hdl/back_emf_observer_pll_unit.sv
sim/bemf_checker.sv
sim/testbench.sv
